### design/radix_integer_parser_assert.svh
`ifndef RADIX_INTEGER_PARSER_ASSERT_SVH
`define RADIX_INTEGER_PARSER_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define RIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_integer_parser assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define RIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix_integer_parser assertion failed");

`endif

### design/rip_pkg.sv
package rip_pkg;

   localparam logic [20:0] CP_PLUS   = 21'h00002b;
   localparam logic [20:0] CP_HYPHEN = 21'h00002d;
   localparam logic [20:0] CP_MINUS  = 21'h002212;

   localparam logic [5:0] RADIX_RESET = 6'd10;
   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] NO_DIGIT    = 6'd63;

   typedef enum logic [2:0] {
      ERR_NONE           = 3'd0,
      ERR_EMPTY          = 3'd1,
      ERR_DOUBLE_SPACE   = 3'd2,
      ERR_ILLEGAL        = 3'd3,
      ERR_OVERFLOW       = 3'd4,
      ERR_TRAILING_SPACE = 3'd5,
      ERR_NO_DIGITS      = 3'd6
   } err_code_type;

   // Unicode space separators (general category Zs).
   function automatic logic is_space_sep(input logic [20:0] c);
      return (c == 21'h000020) || (c == 21'h0000a0) || (c == 21'h001680) ||
             ((c >= 21'h002000) && (c <= 21'h00200a)) ||
             (c == 21'h00202f) || (c == 21'h00205f) || (c == 21'h003000);
   endfunction

   // Value of an ASCII alphanumeric, or NO_DIGIT for anything else.
   function automatic logic [5:0] digit_value(input logic [20:0] c);
      logic [6:0] a;
      logic [5:0] d;
      a = c[6:0];
      d = NO_DIGIT;
      if (c[20:7] == 14'd0) begin
         if ((a >= 7'h30) && (a <= 7'h39)) begin
            d = 6'(a - 7'h30);
         end else if ((a >= 7'h61) && (a <= 7'h7a)) begin
            d = 6'(a - 7'h61 + 7'd10);
         end else if ((a >= 7'h41) && (a <= 7'h5a)) begin
            d = 6'(a - 7'h41 + 7'd10);
         end
      end
      return d;
   endfunction

endpackage

### design/rip_if.sv
interface rip_req_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        is_last;
   logic        is_empty;

   modport source (output valid, output code_point, output is_last, output is_empty,
                   input ready);
   modport sink (input valid, input code_point, input is_last, input is_empty,
                 output ready);
endinterface

interface rip_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic signed [63:0] value;
   logic [2:0]         error_code;
   logic [15:0]        error_position;

   modport source (output valid, output ok, output value, output error_code,
                   output error_position, input ready);
   modport sink (input valid, input ok, input value, input error_code,
                 input error_position, output ready);
endinterface

### design/radix_integer_parser.sv
// Channel  | Direction | Handshake        | Payload
// req_ch   | in        | valid/ready      | code_point, is_last, is_empty
// rsp_ch   | out       | valid/ready      | ok, value, error_code, error_position
// csr_*    | in        | write enable     | radix (6 bits)
//
// One item per cycle sustained while no result is stalled; a result is valid once the item
// that ends its string has passed the input register and then the digit multiply-add and
// overflow compare into the result register.
// The parse state is updated once per cycle by that same multiply-add, which sets the rate.
// Synchronous active-high reset clears the string state and sets the radix to ten.
// A stalled result blocks only an item that itself ends a string, and the items behind it.
module radix_integer_parser #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   rip_req_if.sink           req_ch,
   rip_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);

   logic [5:0] radix_ff;

   // Input register.
   logic        in_v_ff, in_v_in;
   logic [20:0] cp_ff;
   logic        last_ff;
   logic        empty_ff;

   // String state.
   logic [63:0]              acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic                     pend_ff, pend_in;
   logic                     seen_ff, seen_in;
   logic [INDEX_WIDTH-1:0]   idx_ff, idx_in;
   logic                     failed_ff, failed_in;
   rip_pkg::err_code_type    fcode_ff, fcode_in;
   logic [15:0]              fpos_ff, fpos_in;

   // Result register.
   logic                     rsp_v_ff, rsp_v_in;
   logic                     rsp_ok_ff;
   logic [63:0]              rsp_value_ff;
   rip_pkg::err_code_type    rsp_code_ff;
   logic [15:0]              rsp_pos_ff;

   logic                     res_ok;
   logic [63:0]              res_value;
   rip_pkg::err_code_type    res_code;
   logic [15:0]              res_pos;

   logic        gives_result, fire;
   logic        is_first, sign_minus, sign_plus, is_space;
   logic [5:0]  dig;
   logic        digit_ok;
   logic [69:0] prod;
   logic [70:0] sum;
   logic [63:0] limit;
   logic        over;
   logic [15:0] pos_here;

   assign gives_result = empty_ff || last_ff;
   assign fire = in_v_ff && (!gives_result || !rsp_v_ff || rsp_ch.ready);
   assign req_ch.ready = !in_v_ff || fire;

   assign is_first   = (idx_ff == '0);
   assign sign_minus = is_first && ((cp_ff == rip_pkg::CP_HYPHEN) ||
                                    (cp_ff == rip_pkg::CP_MINUS));
   assign sign_plus  = is_first && (cp_ff == rip_pkg::CP_PLUS);
   assign is_space   = !is_first && rip_pkg::is_space_sep(cp_ff);
   assign dig        = rip_pkg::digit_value(cp_ff);
   assign digit_ok   = (radix_ff >= rip_pkg::RADIX_MIN) && (radix_ff <= rip_pkg::RADIX_MAX) &&
                       (dig < radix_ff);
   // The full product never wraps, so the bound compare is exact.
   assign prod  = 70'(acc_ff) * 70'(radix_ff);
   assign sum   = 71'(prod) + 71'(dig);
   assign limit = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
   assign over  = sum > 71'(limit);
   assign pos_here = 16'(idx_ff);

   always_comb begin
      in_v_in   = in_v_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      pend_in   = pend_ff;
      seen_in   = seen_ff;
      idx_in    = idx_ff;
      failed_in = failed_ff;
      fcode_in  = fcode_ff;
      fpos_in   = fpos_ff;
      res_ok    = 1'b0;
      res_value = 64'd0;
      res_code  = rip_pkg::ERR_NONE;
      res_pos   = 16'd0;

      if (req_ch.valid && req_ch.ready) begin
         in_v_in = 1'b1;
      end else if (fire) begin
         in_v_in = 1'b0;
      end

      if (fire) begin
         if (empty_ff) begin
            res_code = rip_pkg::ERR_EMPTY;
         end else begin
            if (!failed_ff) begin
               if (sign_minus) begin
                  neg_in = 1'b1;
               end else if (sign_plus) begin
                  neg_in = neg_ff;
               end else if (is_space) begin
                  if (pend_ff) begin
                     failed_in = 1'b1;
                     fcode_in  = rip_pkg::ERR_DOUBLE_SPACE;
                     fpos_in   = pos_here;
                  end else begin
                     pend_in = 1'b1;
                  end
               end else if (!digit_ok) begin
                  failed_in = 1'b1;
                  fcode_in  = rip_pkg::ERR_ILLEGAL;
                  fpos_in   = pos_here;
               end else if (over) begin
                  failed_in = 1'b1;
                  fcode_in  = rip_pkg::ERR_OVERFLOW;
                  fpos_in   = pos_here;
               end else begin
                  acc_in  = sum[63:0];
                  pend_in = 1'b0;
                  seen_in = 1'b1;
               end
            end
            if (!last_ff) begin
               if (idx_ff != '1) begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (!failed_in && pend_in) begin
                  failed_in = 1'b1;
                  fcode_in  = rip_pkg::ERR_TRAILING_SPACE;
                  fpos_in   = pos_here;
               end
               if (!failed_in && !seen_in) begin
                  failed_in = 1'b1;
                  fcode_in  = rip_pkg::ERR_NO_DIGITS;
                  fpos_in   = 16'd0;
               end
               if (failed_in) begin
                  res_code = fcode_in;
                  res_pos  = fpos_in;
               end else begin
                  res_ok    = 1'b1;
                  res_value = neg_in ? (64'd0 - acc_in) : acc_in;
               end
            end
         end
         // Every result closes the string.
         if (gives_result) begin
            acc_in    = 64'd0;
            neg_in    = 1'b0;
            pend_in   = 1'b0;
            seen_in   = 1'b0;
            idx_in    = '0;
            failed_in = 1'b0;
            fcode_in  = rip_pkg::ERR_NONE;
            fpos_in   = 16'd0;
         end
      end

      if (fire && gives_result) begin
         rsp_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= rip_pkg::RADIX_RESET;
         in_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
         acc_ff    <= 64'd0;
         neg_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         seen_ff   <= 1'b0;
         idx_ff    <= '0;
         failed_ff <= 1'b0;
         fcode_ff  <= rip_pkg::ERR_NONE;
         fpos_ff   <= 16'd0;
      end else begin
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
         in_v_ff   <= in_v_in;
         rsp_v_ff  <= rsp_v_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         pend_ff   <= pend_in;
         seen_ff   <= seen_in;
         idx_ff    <= idx_in;
         failed_ff <= failed_in;
         fcode_ff  <= fcode_in;
         fpos_ff   <= fpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cp_ff    <= req_ch.code_point;
         last_ff  <= req_ch.is_last;
         empty_ff <= req_ch.is_empty;
      end
      if (fire && gives_result) begin
         rsp_ok_ff    <= res_ok;
         rsp_value_ff <= res_value;
         rsp_code_ff  <= res_code;
         rsp_pos_ff   <= res_pos;
      end
   end

   assign rsp_ch.valid          = rsp_v_ff;
   assign rsp_ch.ok             = rsp_ok_ff;
   assign rsp_ch.value          = rsp_value_ff;
   assign rsp_ch.error_code     = rsp_code_ff;
   assign rsp_ch.error_position = rsp_pos_ff;

`include "radix_integer_parser_assert.svh"

   `RIP_ASSERT_NOW(a_ok_no_error, clock, reset, rsp_v_ff && rsp_ok_ff,
      (rsp_code_ff == rip_pkg::ERR_NONE) && (rsp_pos_ff == 16'd0))
   `RIP_ASSERT_NOW(a_failed_has_code, clock, reset, failed_ff, fcode_ff != rip_pkg::ERR_NONE)
   `RIP_ASSERT_NEXT(a_end_clears_string, clock, reset, fire && gives_result,
      (idx_ff == '0) && !failed_ff && !seen_ff && (acc_ff == 64'd0))

endmodule

### dv/tb_radix_integer_parser.sv
module tb_radix_integer_parser;

   localparam logic [20:0] CH_SPACE   = 21'h000020;
   localparam logic [20:0] CH_ZERO    = 21'h000030;
   localparam logic [20:0] CH_UPPER_A = 21'h000041;
   localparam logic [20:0] CH_LOWER_A = 21'h000061;
   localparam logic [20:0] CP_TOP     = 21'h10ffff;
   localparam logic [6:0]  NOT_A_DIGIT = 7'd64;
   localparam logic [63:0] POS_LIMIT  = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;
   localparam int ITEMS_PER_PHASE = 60;

   typedef struct {
      logic [20:0] code_point;
      logic        is_last;
      logic        is_empty;
   } char_item_type;

   typedef struct {
      logic                  ok;
      logic [63:0]           value;
      rip_pkg::err_code_type code;
      logic [15:0]           pos;
   } parse_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [5:0] csr_wr_data;

   rip_req_if req_if ();
   rip_rsp_if rsp_if ();

   radix_integer_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   char_item_type    pending_chars[$];
   parse_result_type expected_results[$];
   logic [20:0]      draft[$];
   int               queued_count = 0;
   int               accepted_count = 0;
   int               mismatch_count = 0;
   bit               item_taken = 1'b0;

   int unsigned   burst_left = 1;
   int unsigned   gap_left = 0;
   logic [15:0]   stall_pattern = '1;
   logic [3:0]    stall_bit = '0;
   int unsigned   stall_span = 0;

   // Parser state as the block should hold it.
   logic [5:0]            parse_radix;
   logic [63:0]           str_acc;
   logic                  str_neg;
   logic                  str_space;
   logic                  str_seen;
   logic [15:0]           str_index;
   logic                  str_failed;
   rip_pkg::err_code_type str_code;
   logic [15:0]           str_pos;

   always #6 clock = ~clock;

   function automatic bit is_zs(input logic [20:0] cp);
      case (cp)
         21'h000020, 21'h0000a0, 21'h001680, 21'h00202f, 21'h00205f, 21'h003000: return 1'b1;
         default: return (cp >= 21'h002000) && (cp <= 21'h00200a);
      endcase
   endfunction

   function automatic logic [6:0] weight_of(input logic [20:0] cp);
      logic [6:0] w;
      w = NOT_A_DIGIT;
      if (parse_radix >= 6'd2 && parse_radix <= 6'd36) begin
         if (cp >= CH_ZERO && cp <= CH_ZERO + 21'd9) begin
            w = 7'(cp - CH_ZERO);
         end else if (cp >= CH_LOWER_A && cp <= CH_LOWER_A + 21'd25) begin
            w = 7'(cp - CH_LOWER_A + 21'd10);
         end else if (cp >= CH_UPPER_A && cp <= CH_UPPER_A + 21'd25) begin
            w = 7'(cp - CH_UPPER_A + 21'd10);
         end
         if (w >= {1'b0, parse_radix}) begin
            w = NOT_A_DIGIT;
         end
      end
      return w;
   endfunction

   function automatic void clear_parse();
      str_acc = '0;
      str_neg = 1'b0;
      str_space = 1'b0;
      str_seen = 1'b0;
      str_index = '0;
      str_failed = 1'b0;
      str_code = rip_pkg::ERR_NONE;
      str_pos = '0;
   endfunction

   function automatic void note_error(input rip_pkg::err_code_type code,
                                      input logic [15:0] pos);
      str_failed = 1'b1;
      str_code = code;
      str_pos = pos;
   endfunction

   function automatic void absorb_char(input logic [20:0] cp);
      logic [6:0] w;
      logic [63:0] limit;
      if (str_index == 0 && (cp == rip_pkg::CP_HYPHEN || cp == rip_pkg::CP_MINUS)) begin
         str_neg = 1'b1;
         return;
      end
      if (str_index == 0 && cp == rip_pkg::CP_PLUS) begin
         return;
      end
      if (str_index != 0 && is_zs(cp)) begin
         if (str_space) begin
            note_error(rip_pkg::ERR_DOUBLE_SPACE, str_index);
         end else begin
            str_space = 1'b1;
         end
         return;
      end
      w = weight_of(cp);
      if (w == NOT_A_DIGIT) begin
         note_error(rip_pkg::ERR_ILLEGAL, str_index);
         return;
      end
      // Negative strings accumulate toward a limit one larger than positive ones.
      limit = str_neg ? NEG_LIMIT : POS_LIMIT;
      if (str_acc > (limit - 64'(w)) / 64'(parse_radix)) begin
         note_error(rip_pkg::ERR_OVERFLOW, str_index);
         return;
      end
      str_acc = str_acc * 64'(parse_radix) + 64'(w);
      str_space = 1'b0;
      str_seen = 1'b1;
   endfunction

   function automatic void advance_parse(input char_item_type it);
      parse_result_type r;
      if (it.is_empty) begin
         r = '{1'b0, 64'd0, rip_pkg::ERR_EMPTY, 16'd0};
         expected_results.push_back(r);
         clear_parse();
         return;
      end
      if (!str_failed) begin
         absorb_char(it.code_point);
      end
      if (!it.is_last) begin
         if (str_index != 16'hffff) begin
            str_index++;
         end
         return;
      end
      if (!str_failed && str_space) begin
         note_error(rip_pkg::ERR_TRAILING_SPACE, str_index);
      end
      if (!str_failed && !str_seen) begin
         note_error(rip_pkg::ERR_NO_DIGITS, 16'd0);
      end
      if (str_failed) begin
         r = '{1'b0, 64'd0, str_code, str_pos};
      end else begin
         r = '{1'b1, str_neg ? 64'd0 - str_acc : str_acc, rip_pkg::ERR_NONE, 16'd0};
      end
      expected_results.push_back(r);
      clear_parse();
   endfunction

   // Stimulus building: characters collect in the draft until the string is closed.
   task automatic put_char(input logic [20:0] cp);
      draft.push_back(cp);
   endtask

   task automatic close_string(input bit mark_last);
      foreach (draft[i]) begin
         pending_chars.push_back('{draft[i], mark_last && (i == draft.size() - 1), 1'b0});
      end
      queued_count += draft.size();
      draft.delete();
   endtask

   task automatic put_empty(input logic last_flag);
      pending_chars.push_back('{21'($urandom_range(0, CP_TOP)), last_flag, 1'b1});
      queued_count++;
   endtask

   function automatic logic [20:0] space_glyph();
      case ($urandom_range(0, 6))
         0: return CH_SPACE;
         1: return 21'h0000a0;
         2: return 21'h001680;
         3: return 21'h002000 + 21'($urandom_range(0, 10));
         4: return 21'h00202f;
         5: return 21'h00205f;
         default: return 21'h003000;
      endcase
   endfunction

   function automatic logic [20:0] sign_glyph();
      case ($urandom_range(0, 2))
         0: return rip_pkg::CP_PLUS;
         1: return rip_pkg::CP_HYPHEN;
         default: return rip_pkg::CP_MINUS;
      endcase
   endfunction

   function automatic logic [20:0] digit_glyph(input logic [5:0] d);
      if (d < 6'd10) begin
         return CH_ZERO + 21'(d);
      end
      return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 21'(d) - 21'd10;
   endfunction

   function automatic logic [20:0] any_glyph();
      case ($urandom_range(0, 7))
         0: return 21'($urandom_range(0, CP_TOP));
         1: return sign_glyph();
         2: return space_glyph();
         3: return CH_ZERO + 21'($urandom_range(0, 9));
         4: return CH_LOWER_A + 21'($urandom_range(0, 25));
         5: return CH_UPPER_A + 21'($urandom_range(0, 25));
         6: return 21'($urandom_range(32, 126));
         default: begin
            // Neighbors of the digit and letter ranges.
            case ($urandom_range(0, 5))
               0: return 21'h00002f;
               1: return 21'h00003a;
               2: return 21'h000040;
               3: return 21'h00005b;
               4: return 21'h000060;
               default: return 21'h00007b;
            endcase
         end
      endcase
   endfunction

   task automatic random_number();
      logic [63:0] mag;
      int unsigned base;
      int unsigned pick;
      logic [5:0] digs[$];
      base = (parse_radix >= 6'd2 && parse_radix <= 6'd36) ? parse_radix
                                                          : $urandom_range(2, 36);
      pick = $urandom_range(0, 11);
      case (pick)
         0, 1, 2, 3, 4: mag = 64'($urandom_range(0, 2000));
         5, 6: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
         7: mag = POS_LIMIT - 64'($urandom_range(0, 1));
         8: mag = NEG_LIMIT;
         9: mag = NEG_LIMIT + 64'($urandom_range(1, 2));
         10: mag = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
         default: mag = 64'd0;
      endcase
      if (pick >= 7 && pick <= 10) begin
         if ($urandom_range(0, 1)) begin
            put_char($urandom_range(0, 1) ? rip_pkg::CP_HYPHEN : rip_pkg::CP_MINUS);
         end
      end else if ($urandom_range(0, 2) == 0) begin
         put_char(sign_glyph());
      end
      do begin
         digs.push_front(6'(mag % 64'(base)));
         mag = mag / 64'(base);
      end while (mag != 0);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 2)) digs.push_front(6'd0);
      end
      if ($urandom_range(0, 11) == 0) begin
         digs.push_back(6'($urandom_range(0, base - 1)));
      end
      foreach (digs[k]) begin
         if (k > 0 && $urandom_range(0, 5) == 0) begin
            put_char(space_glyph());
         end
         put_char(digit_glyph(digs[k]));
      end
      close_string(1'b1);
   endtask

   task automatic broken_string();
      case ($urandom_range(0, 5))
         0: begin
            repeat ($urandom_range(1, 6)) put_char(any_glyph());
            close_string(1'b1);
         end
         1: begin
            put_char(CH_ZERO + 21'($urandom_range(0, 9)));
            put_char(space_glyph());
            put_char(space_glyph());
            put_char(CH_ZERO + 21'($urandom_range(0, 9)));
            close_string(1'b1);
         end
         2: begin
            repeat ($urandom_range(1, 3)) put_char(CH_ZERO + 21'($urandom_range(0, 1)));
            put_char(space_glyph());
            close_string(1'b1);
         end
         3: begin
            // A string cut short by an empty-string item.
            repeat ($urandom_range(1, 4)) put_char(any_glyph());
            close_string(1'b0);
            put_empty($urandom_range(0, 1));
         end
         4: put_empty($urandom_range(0, 1));
         default: begin
            if ($urandom_range(0, 1)) begin
               put_char(space_glyph());
               put_char(CH_ZERO + 21'd1);
            end else begin
               put_char(CH_ZERO + 21'd1);
               put_char(sign_glyph());
               put_char(CH_ZERO + 21'd1);
            end
            close_string(1'b1);
         end
      endcase
   endtask

   task automatic random_phase(input int count);
      int start;
      start = queued_count;
      while (queued_count - start < count) begin
         if ($urandom_range(0, 9) < 7) begin
            random_number();
         end else begin
            broken_string();
         end
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_radix(input logic [5:0] value);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      parse_radix = value;
   endtask

   // Sender: bursts of items separated by random gaps.
   always @(negedge clock) begin
      char_item_type it;
      logic drive;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || item_taken) begin
         item_taken = 1'b0;
         drive = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_chars.size() > 0) begin
            it = pending_chars.pop_front();
            drive = 1'b1;
            req_if.code_point <= it.code_point;
            req_if.is_last <= it.is_last;
            req_if.is_empty <= it.is_empty;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 4) == 0) begin
               burst_left = $urandom_range(20, 60);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = $urandom_range(1, 6);
            end
         end
         req_if.valid <= drive;
      end
   end

   // Receiver: ready follows a 16-bit pattern that is redrawn now and then.
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_pattern = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
         stall_span = $urandom_range(16, 80);
      end
      stall_span--;
      rsp_if.ready <= stall_pattern[stall_bit];
      stall_bit++;
   end

   always @(posedge clock) begin
      parse_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            advance_parse('{req_if.code_point, req_if.is_last, req_if.is_empty});
            accepted_count++;
            item_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with none expected: ok=%0d value=%0d code=%0d pos=%0d",
                      rsp_if.ok, rsp_if.value, rsp_if.error_code, rsp_if.error_position);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.ok !== want.ok) begin
                  $error("ok: expected %0d, actual %0d", want.ok, rsp_if.ok);
                  mismatch_count++;
               end
               if (rsp_if.value !== want.value) begin
                  $error("value: expected %0d, actual %0d", $signed(want.value), rsp_if.value);
                  mismatch_count++;
               end
               if (rsp_if.error_code !== want.code) begin
                  $error("error_code: expected %0d, actual %0d", want.code, rsp_if.error_code);
                  mismatch_count++;
               end
               if (rsp_if.error_position !== want.pos) begin
                  $error("error_position: expected %0d, actual %0d", want.pos,
                         rsp_if.error_position);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      int radix_plan[$];
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.code_point = '0;
      req_if.is_last = 1'b0;
      req_if.is_empty = 1'b0;
      rsp_if.ready = 1'b0;
      parse_radix = rip_pkg::RADIX_RESET;
      clear_parse();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings at the reset radix of ten.
      put_empty(1'b0);
      put_char(rip_pkg::CP_MINUS);
      put_char(CH_ZERO + 21'd1);
      put_char(21'h003000);
      put_char(CH_ZERO + 21'd2);
      close_string(1'b1);
      put_char(rip_pkg::CP_PLUS);
      close_string(1'b1);
      put_char(CH_ZERO + 21'd1);
      put_char(CH_SPACE);
      put_char(21'h0000a0);
      put_char(CH_ZERO + 21'd2);
      close_string(1'b1);
      put_char(CH_ZERO + 21'd5);
      put_char(21'h00202f);
      close_string(1'b1);
      put_char(CH_SPACE);
      put_char(CH_ZERO + 21'd5);
      close_string(1'b1);
      put_char(CH_ZERO + 21'd3);
      put_char(rip_pkg::CP_HYPHEN);
      close_string(1'b1);
      put_char(CH_ZERO + 21'd9);
      close_string(1'b0);
      put_empty(1'b1);
      put_char(21'd0);
      close_string(1'b1);
      put_char(CP_TOP);
      close_string(1'b1);
      put_char(rip_pkg::CP_HYPHEN);
      put_char(CH_UPPER_A + 21'd25);
      close_string(1'b1);

      radix_plan = '{2, 36, 0, 16, 63, 1, 37, 8, 10, 3, 35};
      radix_plan.push_back($urandom_range(2, 36));
      foreach (radix_plan[p]) begin
         set_radix(6'(radix_plan[p]));
         random_phase(ITEMS_PER_PHASE);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
